// ----- design/seconds_to_bcd_calendar_core_macros.svh -----
// assertion helpers shared by the checker
`ifndef SECONDS_TO_BCD_CALENDAR_CORE_MACROS_SVH
`define SECONDS_TO_BCD_CALENDAR_CORE_MACROS_SVH

// clocked assertion, no reset qualification
`define S2BC_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("s2bc assertion failed");

// clocked assertion, held off while reset is asserted
`define S2BC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("s2bc assertion failed");

`endif

// ----- design/s2bc_pkg.sv -----
`timescale 1ns / 1ps
package s2bc_pkg;

  localparam int unsigned RemW = 32;
  localparam int unsigned CntW = 12;

  localparam logic [RemW-1:0] DaySecs     = 32'd86400;
  localparam logic [RemW-1:0] HourSecs    = 32'd3600;
  localparam logic [RemW-1:0] MinSecs     = 32'd60;
  localparam logic [RemW-1:0] TenSecs     = 32'd10;
  localparam logic [RemW-1:0] YearSecs    = 32'd31536000;
  localparam logic [RemW-1:0] LeapYrSecs  = 32'd31622400;

  // year offset (bcd) at which the walk stops: 2245 - 2000
  localparam logic [CntW-1:0] LastYearBcd = 12'h245;
  // last month index, as bcd month number
  localparam logic [4:0]      DecBcd      = 5'h12;
  localparam logic [4:0]      FebBcd      = 5'h02;

  typedef struct packed {
    logic            fits;
    logic [RemW-1:0] diff;
  } sub_res_t;

  // three-digit bcd increment
  function automatic logic [CntW-1:0] bcd_inc(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v[3:0] == 4'd9) begin
      r[3:0] = 4'd0;
      if (v[7:4] == 4'd9) begin
        r[7:4]  = 4'd0;
        r[11:8] = v[11:8] + 4'd1;
      end else begin
        r[7:4] = v[7:4] + 4'd1;
      end
    end else begin
      r[3:0] = v[3:0] + 4'd1;
    end
    return r;
  endfunction

  // gregorian leap rule on a bcd offset from 2000 (2000 itself is leap)
  function automatic logic is_leap(input logic [CntW-1:0] v);
    logic [4:0] s;
    s = {v[7:4], 1'b0} + {1'b0, v[3:0]};
    return (s[1:0] == 2'd0) && (v != 12'h100) && (v != 12'h200);
  endfunction

  // month length in seconds, month given as bcd 1..12
  function automatic logic [RemW-1:0] month_secs(input logic [4:0] m, input logic leap);
    logic [RemW-1:0] r;
    case (m)
      5'h01, 5'h03, 5'h05, 5'h07, 5'h08, 5'h10, 5'h12: r = 32'd2678400;
      5'h04, 5'h06, 5'h09, 5'h11:                      r = 32'd2592000;
      FebBcd:  r = leap ? 32'd2505600 : 32'd2419200;
      default: r = 32'd2678400;
    endcase
    return r;
  endfunction

endpackage

// ----- design/s2bc_sub_unit.sv -----
`timescale 1ns / 1ps
module s2bc_sub_unit (
  input  logic [s2bc_pkg::RemW-1:0] minuend_i,
  input  logic [s2bc_pkg::RemW-1:0] subtrahend_i,
  output s2bc_pkg::sub_res_t        res_o
);
  import s2bc_pkg::*;

  logic [RemW:0] wide;

  // borrow out clear means the operand fits in the remainder
  assign wide       = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign res_o.fits = ~wide[RemW];
  assign res_o.diff = wide[RemW-1:0];

endmodule

// ----- design/seconds_to_bcd_calendar_core.sv -----
`timescale 1ns / 1ps
// Converts a count of seconds since 2000-01-01 00:00:00 into a BCD calendar
// date and time of day (year offset from 2000, month, day, hour, minute,
// second). One item is worked at a time by a single 32-bit subtract and
// compare unit that a small sequencer steps through repeated subtraction of
// year lengths, month lengths, days, hours, minutes and tens of seconds,
// counting each phase directly in BCD. After the last phase the sequencer
// waits in a done state until the output register is free or being emptied,
// then loads the result. The input is ready again in the cycle after the
// load. The result sits in an output register, so the next item is taken
// while a finished result still waits on the output side.
module seconds_to_bcd_calendar_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // elapsed_seconds[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // year_bcd[11:0], month_bcd[16:12], day_bcd[22:17],
                                     // hour_bcd[28:23], minute_bcd[35:29],
                                     // second_bcd[42:36], zero[47:43]
);
  import s2bc_pkg::*;

  // sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StYear  = 3'd1;
  localparam logic [2:0] StMonth = 3'd2;
  localparam logic [2:0] StDay   = 3'd3;
  localparam logic [2:0] StHour  = 3'd4;
  localparam logic [2:0] StMin   = 3'd5;
  localparam logic [2:0] StSec   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic [RemW-1:0] rem_q, rem_d;       // seconds still to be placed
  logic [CntW-1:0] cnt_q, cnt_d;       // bcd count of the running phase
  logic [11:0]     year_q, year_d;
  logic [4:0]      month_q, month_d;
  logic [5:0]      day_q, day_d;
  logic [5:0]      hour_q, hour_d;
  logic [6:0]      min_q, min_d;
  logic [6:0]      sec_q, sec_d;
  logic [47:0]     out_q, out_d;
  logic            load;

  logic [RemW-1:0] operand;
  sub_res_t        sub;

  // operand for the shared subtractor, picked by phase
  always_comb begin
    case (state_q)
      StYear:  operand = is_leap(cnt_q) ? LeapYrSecs : YearSecs;
      StMonth: operand = month_secs(cnt_q[4:0], is_leap(year_q));
      StDay:   operand = DaySecs;
      StHour:  operand = HourSecs;
      StMin:   operand = MinSecs;
      StSec:   operand = TenSecs;
      default: operand = '0;
    endcase
  end

  s2bc_sub_unit u_sub (
    .minuend_i    (rem_q),
    .subtrahend_i (operand),
    .res_o        (sub)
  );

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    load    = 1'b0;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          rem_d   = s_axis_tdata;
          cnt_d   = '0;
          state_d = StYear;
        end
      end
      StYear: begin
        // walk whole years; the bound is never reached by a 32-bit count
        if (sub.fits && (cnt_q != LastYearBcd)) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          year_d  = cnt_q;
          cnt_d   = 12'h001;
          state_d = StMonth;
        end
      end
      StMonth: begin
        // december takes whatever is left
        if (sub.fits && (cnt_q[4:0] != DecBcd)) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          month_d = cnt_q[4:0];
          cnt_d   = 12'h001;
          state_d = StDay;
        end
      end
      StDay: begin
        if (sub.fits) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          day_d   = cnt_q[5:0];
          cnt_d   = '0;
          state_d = StHour;
        end
      end
      StHour: begin
        if (sub.fits) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          hour_d  = cnt_q[5:0];
          cnt_d   = '0;
          state_d = StMin;
        end
      end
      StMin: begin
        if (sub.fits) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          min_d   = cnt_q[6:0];
          cnt_d   = '0;
          state_d = StSec;
        end
      end
      StSec: begin
        // count tens, the units digit is what remains below ten
        if (sub.fits) begin
          rem_d = sub.diff;
          cnt_d = bcd_inc(cnt_q);
        end else begin
          sec_d   = {cnt_q[2:0], rem_q[3:0]};
          state_d = StDone;
        end
      end
      StDone: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || m_axis_tready) begin
          load    = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = load | (out_valid_q & ~m_axis_tready);
  assign out_d = load ? {5'd0, sec_q, min_q, hour_q, day_q, month_q, year_q} : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    out_q   <= out_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- design/s2bc_checker.sv -----
`timescale 1ns / 1ps
`include "seconds_to_bcd_calendar_core_macros.svh"
module s2bc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // one item at a time: no new item right after one is taken
  `S2BC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // a stalled result holds
  `S2BC_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // month and day never come out as zero
  `S2BC_ASSERT(a_month_day_nonzero, clk_i, rst_ni, m_axis_tvalid |-> ((m_axis_tdata[16:12] != 5'd0) && (m_axis_tdata[22:17] != 6'd0)))

  // padding bits stay clear
  `S2BC_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[47:43] == 5'd0))

endmodule

bind seconds_to_bcd_calendar_core s2bc_checker u_s2bc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/seconds_to_bcd_calendar_core_tb.sv -----
`timescale 1ns / 1ps
module seconds_to_bcd_calendar_core_tb;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned DrainCycles = 400;
  localparam longint unsigned SecsPerDay = 86400;

  typedef struct packed {
    logic [4:0]  pad;
    logic [6:0]  second_bcd;
    logic [6:0]  minute_bcd;
    logic [5:0]  hour_bcd;
    logic [5:0]  day_bcd;
    logic [4:0]  month_bcd;
    logic [11:0] year_bcd;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  logic [31:0] pending_secs[$];
  calendar_t   expected_dates[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned secs_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned n_errors = 0;

  seconds_to_bcd_calendar_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1:        return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:  return 31;
    endcase
  endfunction

  function automatic logic [11:0] to_bcd3(int unsigned v);
    return {4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // calendar date of a seconds count, month index 0 is january
  function automatic calendar_t to_calendar(logic [31:0] secs);
    longint unsigned rest;
    longint unsigned span;
    int unsigned     yr;
    int unsigned     mon;
    bit              leap;
    calendar_t       c;
    rest = secs;
    yr = 2000;
    forever begin
      span = (leap_year(yr) ? 366 : 365) * SecsPerDay;
      if (rest < span) break;
      rest -= span;
      yr++;
    end
    leap = leap_year(yr);
    mon = 0;
    // december takes whatever is left
    while (mon < 11) begin
      span = month_days(mon, leap) * SecsPerDay;
      if (rest < span) break;
      rest -= span;
      mon++;
    end
    c = '0;
    c.year_bcd   = to_bcd3(yr - 2000);
    c.month_bcd  = 5'(to_bcd3(mon + 1));
    c.day_bcd    = 6'(to_bcd3(int'(rest / SecsPerDay) + 1));
    rest %= SecsPerDay;
    c.hour_bcd   = 6'(to_bcd3(int'(rest / 3600)));
    rest %= 3600;
    c.minute_bcd = 7'(to_bcd3(int'(rest / 60)));
    c.second_bcd = 7'(to_bcd3(int'(rest % 60)));
    return c;
  endfunction

  // first second of a month, year given as offset from 2000
  function automatic longint unsigned month_start(int unsigned yoff, int unsigned m);
    longint unsigned days;
    days = 0;
    for (int unsigned y = 2000; y < 2000 + yoff; y++) days += leap_year(y) ? 366 : 365;
    for (int unsigned k = 0; k < m; k++) days += month_days(k, leap_year(2000 + yoff));
    return days * SecsPerDay;
  endfunction

  // random input: just under half uniform, the rest packed around month and day edges
  function automatic logic [31:0] random_secs();
    longint signed   t;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 45) return $urandom;
    t = longint'(month_start($urandom_range(136), $urandom_range(11)));
    t += (longint'($urandom_range(6)) - 3) * longint'(SecsPerDay);
    case ($urandom_range(3))
      0:       t += 0;
      1:       t += 86399;
      2:       t += 60 * $urandom_range(1439) + 59;
      default: t += $urandom_range(86399);
    endcase
    if (t < 0) t = 0;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return 32'(t);
  endfunction

  // input side driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(to_calendar(s_axis_tdata));
        void'(pending_secs.pop_front());
        secs_taken <= secs_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_secs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_secs[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // output side monitor, with one long hold-off so the block backs up
  always @(posedge clk_i) begin
    calendar_t got;
    calendar_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = calendar_t'(m_axis_tdata);
        if (expected_dates.size() == 0) begin
          $error("result %0h with no item outstanding", m_axis_tdata);
          n_errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year_bcd", want.year_bcd, got.year_bcd);
          check_field("month_bcd", want.month_bcd, got.month_bcd);
          check_field("day_bcd", want.day_bcd, got.day_bcd);
          check_field("hour_bcd", want.hour_bcd, got.hour_bcd);
          check_field("minute_bcd", want.minute_bcd, got.minute_bcd);
          check_field("second_bcd", want.second_bcd, got.second_bcd);
          check_field("pad", want.pad, got.pad);
        end
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && secs_taken >= 100) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_secs.size() > 0 || expected_dates.size() > 0) @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_secs.push_back(random_secs());
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // phase one: sender mostly busy, receiver mostly stalled
    send_idle_pct = 6;
    recv_idle_pct = 88;
    pending_secs.push_back(32'd0);
    pending_secs.push_back(32'hFFFF_FFFF);
    pending_secs.push_back(32'hAAAA_AAAA);
    pending_secs.push_back(32'h5555_5555);
    pending_secs.push_back(32'd59);
    pending_secs.push_back(32'd60);
    pending_secs.push_back(32'd3599);
    pending_secs.push_back(32'd3600);
    pending_secs.push_back(32'd86399);
    pending_secs.push_back(32'd86400);
    // end of january and the leap day of 2000
    pending_secs.push_back(32'(31 * SecsPerDay - 1));
    pending_secs.push_back(32'(31 * SecsPerDay));
    pending_secs.push_back(32'(59 * SecsPerDay));
    pending_secs.push_back(32'(60 * SecsPerDay));
    // last second of december and new year
    pending_secs.push_back(32'(366 * SecsPerDay - 1));
    pending_secs.push_back(32'(366 * SecsPerDay));
    pending_secs.push_back(32'((366 + 59) * SecsPerDay));
    // 2004 leap day, 2100 is not a leap year
    pending_secs.push_back(32'(month_start(4, 1) + 28 * SecsPerDay));
    pending_secs.push_back(32'(month_start(100, 0) - 1));
    pending_secs.push_back(32'(month_start(100, 2) - 1));
    pending_secs.push_back(32'(month_start(100, 2)));
    pending_secs.push_back(32'(month_start(136, 11) + 86399));
    queue_random(310);
    wait_drained();

    // phase two: sender mostly idle, receiver mostly ready
    send_idle_pct = 88;
    recv_idle_pct = 6;
    queue_random(330);
    wait_drained();

    // phase three: back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(340);
    wait_drained();

    repeat (DrainCycles) @(negedge clk_i);
    if (expected_dates.size() > 0) begin
      $error("%0d results never arrived", expected_dates.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
